FILE: design/plt_pkg.sv
// ----------------------------------------------------------------------------
// plt_pkg
// shared types and constants for the positional list table
// ----------------------------------------------------------------------------
`default_nettype none

package plt_pkg;

  localparam int CAPACITY_DEF = 64;

  localparam int ACT_W = 2;
  localparam int POS_W = 7;
  localparam int VAL_W = 8;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_GET    = 2'd2,
    ACT_LOCATE = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_PUT,
    ST_FIN
  } state_t;

endpackage

`default_nettype wire

FILE: design/plt_ifs.sv
// ----------------------------------------------------------------------------
// plt request / response channels
// valid/ready channels carrying one list request or one list response
// ----------------------------------------------------------------------------
`default_nettype none

interface plt_req_if;
  logic                        valid;
  logic                        ready;
  logic [plt_pkg::ACT_W-1:0]   action;
  logic [plt_pkg::POS_W-1:0]   position;
  logic [plt_pkg::VAL_W-1:0]   value;

  modport source (output valid, action, position, value, input ready);
  modport sink   (input valid, action, position, value, output ready);
endinterface

interface plt_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        ok;
  logic [plt_pkg::VAL_W-1:0]   value_out;
  logic [plt_pkg::POS_W-1:0]   found_position;
  logic [plt_pkg::POS_W-1:0]   list_length;
  logic                        is_empty;

  modport source (output valid, ok, value_out, found_position, list_length, is_empty,
                  input ready);
  modport sink   (input valid, ok, value_out, found_position, list_length, is_empty,
                  output ready);
endinterface

`default_nettype wire

FILE: design/plt_ram.sv
// ----------------------------------------------------------------------------
// plt_ram
// single write port, single read port entry store, registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module plt_ram #(
  parameter int DEPTH = plt_pkg::CAPACITY_DEF,
  parameter int WIDTH = plt_pkg::VAL_W
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wa,
  input  wire logic [WIDTH-1:0]         wd,
  input  wire logic [$clog2(DEPTH)-1:0] ra,
  output logic      [WIDTH-1:0]         rd
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    rd <= mem[ra];
  end

endmodule

`default_nettype wire

FILE: design/positional_list_table.sv
// ----------------------------------------------------------------------------
// positional_list_table
// ordered byte list in one entry store: insert, delete, get, locate by value
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+---------------------------------------------
//  req     | in  | valid / ready | action, position, value
//  rsp     | out | valid / ready | ok, value_out, found_position, list_length,
//          |     |               | is_empty
//
//  one transaction at a time; the entry store has one read and one write port,
//  so shifts and searches walk one entry per cycle
//  insert shifts the entries from the position up by one, top entry first, then
//  writes the new value; delete shifts the entries above the position down by
//  one; get reads the one entry; locate walks from the head and stops at the
//  first match; a rejected request goes straight to the response
//  reset clears the length and the control state; the store needs no clearing
//  a stalled response is held in the output register while the next request
//  is taken; the block only waits on rsp.ready when a second result is ready
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_table #(
  parameter int CAPACITY = plt_pkg::CAPACITY_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  plt_req_if.sink    req,
  plt_rsp_if.source  rsp
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  // compare width, wide enough for position, count and count + 1
  localparam int EW = ((CW > plt_pkg::POS_W) ? CW : plt_pkg::POS_W) + 1;

  // control state
  plt_pkg::state_t state, state_next;
  logic [CW-1:0]   cnt;
  logic            rd_pend;
  logic            out_valid;

  // request held for the whole transaction
  plt_pkg::action_t         act;
  logic [AW-1:0]            pos_a;      // position - 1
  logic [plt_pkg::VAL_W-1:0] val;

  // walk pointer
  logic [AW-1:0] idx;
  logic [AW-1:0] last;
  logic          up;
  logic [AW-1:0] rd_tag;              // address of the data now on rd_data

  // result under construction
  logic                      r_ok;
  logic [plt_pkg::VAL_W-1:0] r_vout;
  logic [plt_pkg::POS_W-1:0] r_found;

  // output register
  logic                      o_ok;
  logic [plt_pkg::VAL_W-1:0] o_vout;
  logic [plt_pkg::POS_W-1:0] o_found;
  logic [plt_pkg::POS_W-1:0] o_len;
  logic                      o_empty;

  // store ports
  logic                      we;
  logic [AW-1:0]             wa;
  logic [plt_pkg::VAL_W-1:0] wd;
  logic [plt_pkg::VAL_W-1:0] rd_data;
  logic                      rd_issue;

  // ---------------------------------------------------------------- decode
  plt_pkg::action_t req_act;
  logic [EW-1:0]    pos_e;
  logic [EW-1:0]    cnt_e;
  logic             pos_nz;
  logic             in_len;         // 1 <= position <= count
  logic             ins_ok;         // 1 <= position <= count + 1, not full
  logic [AW-1:0]    pos_m1;
  logic [AW-1:0]    cnt_m1;
  logic             go_scan;
  logic             go_put;
  logic             start_ok;
  logic [AW-1:0]    start_idx;
  logic [AW-1:0]    start_last;
  logic             start_up;
  logic             accept;
  logic             out_free;
  logic             loc_hit;

  assign accept   = req.valid && req.ready;
  assign out_free = !out_valid || rsp.ready;

  always_comb begin
    req_act    = plt_pkg::action_t'(req.action);
    pos_e      = EW'(req.position);
    cnt_e      = EW'(cnt);
    pos_nz     = (pos_e != '0);
    in_len     = pos_nz && (pos_e <= cnt_e);
    ins_ok     = pos_nz && (pos_e <= cnt_e + EW'(1)) && (cnt_e < EW'(CAPACITY));
    pos_m1     = AW'(pos_e - EW'(1));
    cnt_m1     = AW'(cnt_e - EW'(1));
    go_scan    = 1'b0;
    go_put     = 1'b0;
    start_ok   = 1'b0;
    start_idx  = pos_m1;
    start_last = pos_m1;
    start_up   = 1'b1;
    case (req_act)
      plt_pkg::ACT_INSERT: begin
        start_ok = ins_ok;
        // shift the tail up, walking down from the top entry
        go_scan    = ins_ok && in_len;
        go_put     = ins_ok && !in_len;
        start_idx  = cnt_m1;
        start_last = pos_m1;
        start_up   = 1'b0;
      end
      plt_pkg::ACT_DELETE: begin
        start_ok   = in_len;
        go_scan    = in_len;
        start_last = cnt_m1;
      end
      plt_pkg::ACT_GET: begin
        start_ok = in_len;
        go_scan  = in_len;
      end
      plt_pkg::ACT_LOCATE: begin
        go_scan    = (cnt != '0);
        start_idx  = '0;
        start_last = cnt_m1;
      end
      default: begin
        go_scan = 1'b0;
      end
    endcase
  end

  // locate match on the data returned by the store
  assign loc_hit = rd_pend && (act == plt_pkg::ACT_LOCATE) && (rd_data == val);

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_next = state;
    case (state)
      plt_pkg::ST_IDLE: begin
        if (req.valid) begin
          if (go_scan) state_next = plt_pkg::ST_SCAN;
          else if (go_put) state_next = plt_pkg::ST_PUT;
          else state_next = plt_pkg::ST_FIN;
        end
      end
      plt_pkg::ST_SCAN: begin
        if (loc_hit) state_next = plt_pkg::ST_FIN;
        else if (idx == last) state_next = plt_pkg::ST_DRAIN;
      end
      plt_pkg::ST_DRAIN: begin
        if (act == plt_pkg::ACT_INSERT) state_next = plt_pkg::ST_PUT;
        else state_next = plt_pkg::ST_FIN;
      end
      plt_pkg::ST_PUT: begin
        state_next = plt_pkg::ST_FIN;
      end
      plt_pkg::ST_FIN: begin
        if (out_free) state_next = plt_pkg::ST_IDLE;
      end
      default: begin
        state_next = plt_pkg::ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------- store control
  always_comb begin
    rd_issue = 1'b0;
    we       = 1'b0;
    wa       = rd_tag;
    wd       = rd_data;
    case (state)
      plt_pkg::ST_SCAN, plt_pkg::ST_DRAIN: begin
        rd_issue = (state == plt_pkg::ST_SCAN) && !loc_hit;
        if (rd_pend) begin
          if (act == plt_pkg::ACT_INSERT) begin
            // entry moves one place up
            we = 1'b1;
            wa = rd_tag + AW'(1);
          end else if (act == plt_pkg::ACT_DELETE && rd_tag != pos_a) begin
            // entry moves one place down over the removed one
            we = 1'b1;
            wa = rd_tag - AW'(1);
          end
        end
      end
      plt_pkg::ST_PUT: begin
        we = 1'b1;
        wa = pos_a;
        wd = val;
      end
      default: begin
        rd_issue = 1'b0;
      end
    endcase
  end

  plt_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (plt_pkg::VAL_W)
  ) u_ram (
    .clk (clk),
    .we  (we),
    .wa  (wa),
    .wd  (wd),
    .ra  (idx),
    .rd  (rd_data)
  );

  // ---------------------------------------------------------------- control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= plt_pkg::ST_IDLE;
      cnt       <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= rd_issue;
      if (state == plt_pkg::ST_DRAIN && act == plt_pkg::ACT_DELETE) begin
        cnt <= cnt - CW'(1);
      end else if (state == plt_pkg::ST_PUT) begin
        cnt <= cnt + CW'(1);
      end
      if (state == plt_pkg::ST_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- payload registers
  always_ff @(posedge clk) begin
    rd_tag <= idx;
    if (accept) begin
      act     <= req_act;
      pos_a   <= pos_m1;
      val     <= req.value;
      idx     <= start_idx;
      last    <= start_last;
      up      <= start_up;
      r_ok    <= start_ok;
      r_vout  <= '0;
      r_found <= '0;
    end else if (state == plt_pkg::ST_SCAN) begin
      idx <= up ? idx + AW'(1) : idx - AW'(1);
    end
    // removed or read entry is the first one returned
    if (rd_pend && rd_tag == pos_a &&
        (act == plt_pkg::ACT_DELETE || act == plt_pkg::ACT_GET)) begin
      r_vout <= rd_data;
    end
    if (loc_hit) begin
      r_ok    <= 1'b1;
      r_found <= plt_pkg::POS_W'(EW'(rd_tag) + EW'(1));
    end
    if (state == plt_pkg::ST_FIN && out_free) begin
      o_ok    <= r_ok;
      o_vout  <= r_vout;
      o_found <= r_found;
      o_len   <= plt_pkg::POS_W'(cnt);
      o_empty <= (cnt == '0);
    end
  end

  assign req.ready          = (state == plt_pkg::ST_IDLE);
  assign rsp.valid          = out_valid;
  assign rsp.ok             = o_ok;
  assign rsp.value_out      = o_vout;
  assign rsp.found_position = o_found;
  assign rsp.list_length    = o_len;
  assign rsp.is_empty       = o_empty;

  // ---------------------------------------------------------------- assertions
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(CAPACITY))
    else $error("list length above capacity");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != plt_pkg::ST_IDLE)
    else $error("accepted request did not start");

  a_put_room: assert property (@(posedge clk) disable iff (rst)
    state == plt_pkg::ST_PUT |-> EW'(cnt) < EW'(CAPACITY))
    else $error("insert write into a full list");

  a_drain_data: assert property (@(posedge clk) disable iff (rst)
    state == plt_pkg::ST_DRAIN |-> rd_pend)
    else $error("drain without read data in flight");

  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    we |-> (state == plt_pkg::ST_SCAN || state == plt_pkg::ST_DRAIN ||
            state == plt_pkg::ST_PUT))
    else $error("store write outside a walk");

endmodule

`default_nettype wire

FILE: bench/positional_list_table_tb.sv
// ----------------------------------------------------------------------------
// positional_list_table_tb
// self-checking bench for the ordered byte list: a queue-fed driver offers
// insert, delete, get and locate requests in random bursts, a shadow copy of
// the list predicts every response, and a monitor compares them field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module positional_list_table_tb;

  localparam int CAPACITY       = plt_pkg::CAPACITY_DEF;
  localparam int RANDOM_ITEMS   = 1050;
  localparam int CYCLE_LIMIT    = 800000;
  localparam int HOLDOFF_AT     = 300;   // accepted requests before the long stall
  localparam int HOLDOFF_CYCLES = 400;
  localparam int SETTLE_CYCLES  = 100;
  localparam int REPORT_CAP     = 50;

  // one request as queued for the driver
  typedef struct {
    plt_pkg::action_t          act;
    logic [plt_pkg::POS_W-1:0] pos;
    logic [plt_pkg::VAL_W-1:0] val;
    bit                        wait_idle;  // hold this one back until all responses are in
  } list_request_t;

  // one predicted response
  typedef struct {
    logic                      ok;
    logic [plt_pkg::VAL_W-1:0] value_out;
    logic [plt_pkg::POS_W-1:0] found_position;
    logic [plt_pkg::POS_W-1:0] list_length;
    logic                      is_empty;
  } list_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  plt_req_if req_ch ();
  plt_rsp_if rsp_ch ();

  positional_list_table #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // 2 ns period
  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // shadow list used to predict responses
  // --------------------------------------------------------------------------
  logic [plt_pkg::VAL_W-1:0] shadow_entries [CAPACITY];
  int                        shadow_len;

  // applies one accepted request to the shadow list and returns the response
  function automatic list_result_t apply_list_request(plt_pkg::action_t act,
                                                      logic [plt_pkg::POS_W-1:0] pos,
                                                      logic [plt_pkg::VAL_W-1:0] val);
    list_result_t r;
    int           p;
    r = '{ok: 1'b0, value_out: '0, found_position: '0, list_length: '0, is_empty: 1'b0};
    p = int'(pos);
    case (act)
      plt_pkg::ACT_INSERT: begin
        // position may be one past the end; a full list rejects everything
        if (p >= 1 && p <= shadow_len + 1 && shadow_len < CAPACITY) begin
          for (int j = shadow_len; j > p - 1; j--) shadow_entries[j] = shadow_entries[j-1];
          shadow_entries[p-1] = val;
          shadow_len++;
          r.ok = 1'b1;
        end
      end
      plt_pkg::ACT_DELETE: begin
        if (p >= 1 && p <= shadow_len) begin
          r.value_out = shadow_entries[p-1];
          for (int j = p - 1; j + 1 < shadow_len; j++) shadow_entries[j] = shadow_entries[j+1];
          shadow_len--;
          r.ok = 1'b1;
        end
      end
      plt_pkg::ACT_GET: begin
        if (p >= 1 && p <= shadow_len) begin
          r.value_out = shadow_entries[p-1];
          r.ok = 1'b1;
        end
      end
      default: begin
        // locate: first matching position wins, position field is ignored
        for (int j = 0; j < shadow_len; j++) begin
          if (!r.ok && shadow_entries[j] == val) begin
            r.found_position = plt_pkg::POS_W'(j + 1);
            r.ok = 1'b1;
          end
        end
      end
    endcase
    r.list_length = plt_pkg::POS_W'(shadow_len);
    r.is_empty    = (shadow_len == 0);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // shared bench state
  // --------------------------------------------------------------------------
  list_request_t request_backlog [$];   // requests not yet offered
  list_result_t  awaited_results [$];   // predicted responses, oldest first
  int            accepted_n  = 0;
  int            error_count = 0;
  int            cycle_count = 0;

  task automatic report_mismatch(string what, int got, int want);
    if (error_count < REPORT_CAP)
      $display("[%0t] mismatch in %s: got %0d, want %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // --------------------------------------------------------------------------
  // request driver: bursts of random length with random gaps between them
  // --------------------------------------------------------------------------
  int burst_left;
  int gap_left;

  always @(posedge clk) begin
    list_request_t next_req;
    logic          offering;
    if (rst) begin
      req_ch.valid <= 1'b0;
      shadow_len = 0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      offering = req_ch.valid;
      // transaction taken at this edge: predict its response right away
      if (req_ch.valid && req_ch.ready) begin
        awaited_results.push_back(apply_list_request(plt_pkg::action_t'(req_ch.action),
                                                     req_ch.position, req_ch.value));
        accepted_n++;
        offering = 1'b0;
      end
      if (!offering) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (request_backlog.size() > 0 &&
                     !(request_backlog[0].wait_idle && awaited_results.size() > 0)) begin
          next_req = request_backlog.pop_front();
          req_ch.action   <= next_req.act;
          req_ch.position <= next_req.pos;
          req_ch.value    <= next_req.val;
          offering = 1'b1;
          // end of a burst picks the next gap; a quarter of the gaps are empty
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
      // single update of valid per edge, so back-to-back offers keep it high
      req_ch.valid <= offering;
    end
  end

  // --------------------------------------------------------------------------
  // long receiver hold-off, counted here, so the block fills and stalls req
  // --------------------------------------------------------------------------
  int holdoff_left;
  bit holdoff_done;

  always @(posedge clk) begin
    if (rst) begin
      holdoff_left <= 0;
      holdoff_done <= 1'b0;
    end else if (!holdoff_done && accepted_n >= HOLDOFF_AT) begin
      holdoff_left <= HOLDOFF_CYCLES;
      holdoff_done <= 1'b1;
    end else if (holdoff_left > 0) begin
      holdoff_left <= holdoff_left - 1;
    end
  end

  // --------------------------------------------------------------------------
  // response ready: a rotating stall pattern, reloaded when its age counter wraps
  // --------------------------------------------------------------------------
  logic [15:0] stall_pattern;
  int          pattern_age;

  always @(posedge clk) begin
    logic [15:0] next_pattern;
    if (rst) begin
      rsp_ch.ready  <= 1'b0;
      stall_pattern <= '1;
      pattern_age   <= 0;
    end else begin
      if (pattern_age == 127) begin
        // one window in four runs with no stalls at all
        next_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
        pattern_age  <= 0;
      end else begin
        next_pattern = {stall_pattern[0], stall_pattern[15:1]};
        pattern_age  <= pattern_age + 1;
      end
      stall_pattern <= next_pattern;
      rsp_ch.ready  <= next_pattern[0] && (holdoff_left == 0);
    end
  end

  // --------------------------------------------------------------------------
  // response monitor: compare each transaction with the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    list_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("response with none outstanding", 1, 0);
      end else begin
        want = awaited_results.pop_front();
        if (rsp_ch.ok !== want.ok)
          report_mismatch("ok", rsp_ch.ok, want.ok);
        if (rsp_ch.value_out !== want.value_out)
          report_mismatch("value_out", rsp_ch.value_out, want.value_out);
        if (rsp_ch.found_position !== want.found_position)
          report_mismatch("found_position", rsp_ch.found_position, want.found_position);
        if (rsp_ch.list_length !== want.list_length)
          report_mismatch("list_length", rsp_ch.list_length, want.list_length);
        if (rsp_ch.is_empty !== want.is_empty)
          report_mismatch("is_empty", rsp_ch.is_empty, want.is_empty);
      end
    end
  end

  // --------------------------------------------------------------------------
  // watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // stimulus generation: the list length is tracked here so that most
  // positions land in range and fill / drain sequences reach the extremes
  // --------------------------------------------------------------------------
  int gen_len       = 0;
  bit gen_wait_idle = 1'b0;

  task automatic push_request(plt_pkg::action_t act, int pos, int val);
    list_request_t item;
    item.act       = act;
    item.pos       = plt_pkg::POS_W'(pos);
    item.val       = plt_pkg::VAL_W'(val);
    item.wait_idle = gen_wait_idle;
    gen_wait_idle  = 1'b0;
    // only the length matters for choosing later positions
    if (act == plt_pkg::ACT_INSERT && pos >= 1 && pos <= gen_len + 1 && gen_len < CAPACITY)
      gen_len++;
    else if (act == plt_pkg::ACT_DELETE && pos >= 1 && pos <= gen_len)
      gen_len--;
    request_backlog.push_back(item);
  endtask

  // small values half the time so that locates hit and duplicates occur
  function automatic int pick_value();
    return ($urandom_range(0, 1) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 255);
  endfunction

  function automatic int in_range_position(plt_pkg::action_t act);
    if (act == plt_pkg::ACT_INSERT) return $urandom_range(1, gen_len + 1);
    return $urandom_range(1, (gen_len > 0) ? gen_len : 1);
  endfunction

  initial begin
    int               target;
    int               phase_n;
    int               kind;
    plt_pkg::action_t act;

    // known values on every block input from time zero
    req_ch.valid    = 1'b0;
    req_ch.action   = plt_pkg::ACT_INSERT;
    req_ch.position = '0;
    req_ch.value    = '0;
    rsp_ch.ready    = 1'b0;

    // directed: empty list, edges of the position range, ends and middle
    push_request(plt_pkg::ACT_GET, 1, 0);           // get on empty list
    push_request(plt_pkg::ACT_DELETE, 1, 0);        // delete on empty list
    push_request(plt_pkg::ACT_LOCATE, 0, 0);        // locate on empty list
    push_request(plt_pkg::ACT_INSERT, 0, 8'h11);    // position zero
    push_request(plt_pkg::ACT_INSERT, 2, 8'h22);    // past length plus one
    push_request(plt_pkg::ACT_INSERT, 1, 8'hFF);
    push_request(plt_pkg::ACT_INSERT, 1, 8'h00);    // at the head
    push_request(plt_pkg::ACT_INSERT, 3, 8'hA5);    // at the tail
    push_request(plt_pkg::ACT_INSERT, 2, 8'h5A);    // in the middle
    for (int p = 1; p <= 5; p++) push_request(plt_pkg::ACT_GET, p, 0);
    push_request(plt_pkg::ACT_GET, 0, 0);
    push_request(plt_pkg::ACT_GET, 127, 8'hFF);     // all position bits set
    push_request(plt_pkg::ACT_DELETE, 127, 0);
    push_request(plt_pkg::ACT_INSERT, 127, 8'h77);
    push_request(plt_pkg::ACT_LOCATE, 127, 8'hFF);  // position ignored by locate
    push_request(plt_pkg::ACT_LOCATE, 0, 8'h00);
    push_request(plt_pkg::ACT_LOCATE, 0, 8'h33);    // miss
    push_request(plt_pkg::ACT_DELETE, 4, 0);        // last entry
    push_request(plt_pkg::ACT_DELETE, 1, 0);        // first entry
    push_request(plt_pkg::ACT_DELETE, 0, 0);
    push_request(plt_pkg::ACT_DELETE, 2, 0);
    push_request(plt_pkg::ACT_DELETE, 1, 0);        // back to empty

    // random phases; the first one always fills the list to capacity
    target  = request_backlog.size() + RANDOM_ITEMS;
    phase_n = 0;
    while (request_backlog.size() < target) begin
      kind = (phase_n == 0) ? 0 : $urandom_range(0, 3);
      // some phases start only after every response has come back
      gen_wait_idle = (phase_n == 1) || ($urandom_range(0, 3) == 0);
      case (kind)
        0: begin
          // fill to full, then inserts that a full list must reject
          while (gen_len < CAPACITY) begin
            if ($urandom_range(0, 6) != 0) begin
              push_request(plt_pkg::ACT_INSERT, in_range_position(plt_pkg::ACT_INSERT),
                           pick_value());
            end else begin
              act = plt_pkg::action_t'($urandom_range(2, 3));
              push_request(act, in_range_position(act), pick_value());
            end
          end
          repeat (2) push_request(plt_pkg::ACT_INSERT, $urandom_range(1, CAPACITY + 1),
                                  pick_value());
          push_request(plt_pkg::ACT_GET, CAPACITY, pick_value());
          push_request(plt_pkg::ACT_LOCATE, $urandom_range(0, 127), pick_value());
        end
        1: begin
          // drain to empty, then one delete too many
          while (gen_len > 0) begin
            if ($urandom_range(0, 6) != 0) begin
              push_request(plt_pkg::ACT_DELETE, in_range_position(plt_pkg::ACT_DELETE),
                           pick_value());
            end else begin
              act = plt_pkg::action_t'($urandom_range(2, 3));
              push_request(act, in_range_position(act), pick_value());
            end
          end
          push_request(plt_pkg::ACT_DELETE, $urandom_range(0, 1), pick_value());
        end
        2: begin
          // every action, one position in five anywhere in the field
          repeat (40) begin
            act = plt_pkg::action_t'($urandom_range(0, 3));
            if ($urandom_range(0, 4) == 0)
              push_request(act, $urandom_range(0, 127), pick_value());
            else
              push_request(act, in_range_position(act), pick_value());
          end
        end
        default: begin
          // reads only
          repeat (30) begin
            act = plt_pkg::action_t'($urandom_range(2, 3));
            push_request(act, in_range_position(act), pick_value());
          end
        end
      endcase
      phase_n++;
    end

    // reset is held, then released at a rising edge
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // run until everything is offered, taken and answered
    while (request_backlog.size() > 0 || req_ch.valid || awaited_results.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
